@@ rtl/tvac_pkg.sv @@
// Shared types and constants for the taut / veering angle classifier.
// Used by every module of the block; depends on nothing.
package tvac_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_EDGES_DEF  = 1024;
    localparam int ANGLE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int EDGE_BITS   = 10;
    localparam int ORIENT_BITS = 2;
    localparam int OUT_TDATA_W = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIENT = 1'b1;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // Each tetrahedron issues four paint slots to the colour table.
    localparam int SLOT_BITS = 2;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = 2'd3;

    // Epoch tags on colour table entries; tag zero marks a cleared entry.
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = 8'hFF;
    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = 8'd0;

    // One colour write request: neg set means colour minus one.
    typedef struct packed {
        logic                 vld;
        logic                 neg;
        logic [EDGE_BITS-1:0] edge_idx;
    } paint_t;

    // One classified tetrahedron as it travels through the queue.
    typedef struct packed {
        paint_t [3:0] paint;
        logic         last;
        logic         empty;
        logic         strict;
        logic         taut;
    } item_cmd_t;

    // One result beat, is_strict in the lowest bit.
    typedef struct packed {
        logic is_veering;
        logic is_taut;
        logic is_strict;
    } result_t;

    // Back-end sequencer states.
    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } back_state_t;

endpackage

@@ rtl/taut_veering_angle_classifier_top.sv @@
// Top level of the taut / veering angle classifier: stream ports, configuration
// registers and the front, queue and back instances. Depends on tvac_pkg.
//
// Each tetrahedron beat is classified on acceptance and queued; the back end then
// runs its four colour-table paints in turn, as the table has one write port;
// one read-modify-write completes per cycle unless the table is being swept or a
// waiting result holds the last paint of a structure. Its result beat then passes
// the paint-stage and output registers. Table entries carry an epoch tag, so a
// new structure starts without clearing; after reset and every 255 structures the
// table is swept once over all MAX_EDGES entries (1024 by default), during which
// beats still queue up but no paints run. The user must ensure configuration is
// written only while the block is idle; the block itself does not enforce it.
module taut_veering_angle_classifier_top #(
    parameter int MAX_EDGES  = tvac_pkg::MAX_EDGES_DEF,
    parameter int ANGLE_BITS = tvac_pkg::ANGLE_BITS_DEF,
    localparam int IN_BITS   = 3 * ANGLE_BITS + tvac_pkg::ORIENT_BITS
                             + 6 * tvac_pkg::EDGE_BITS,
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [tvac_pkg::CFG_IDX_BITS-1:0] cfg_addr,
    input  logic [ANGLE_BITS-1:0]             cfg_wdata,
    // Tetrahedron beats.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // angle_a, angle_b, angle_c, orient_sign, edge_0 .. edge_5, zero fill
    input  logic [S_TDATA_W-1:0]              s_tdata,
    input  logic                              s_tlast,   // last_tet
    input  logic                              s_tuser,   // no_tets
    // Result beats.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // is_strict, is_taut, is_veering, zero fill
    output logic [tvac_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int EDGE_LO   = 3 * ANGLE_BITS + tvac_pkg::ORIENT_BITS;

    logic [ANGLE_BITS-1:0] scale_value_reg;
    logic                  orientable_reg;

    logic [5:0][tvac_pkg::EDGE_BITS-1:0] edges;
    logic                cmd_valid, cmd_ready, q_valid, q_ready;
    tvac_pkg::item_cmd_t cmd_data, q_data;
    tvac_pkg::result_t   res_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_value_reg <= '0;
            orientable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tvac_pkg::REG_SCALE:
                begin
                    scale_value_reg <= cfg_wdata;
                end
                tvac_pkg::REG_ORIENT:
                begin
                    orientable_reg <= cfg_wdata[0];
                end
                default:
                begin
                    orientable_reg <= orientable_reg;
                end
            endcase
        end
    end

    // Unpack the edge indexes.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            edges[i] = s_tdata[EDGE_LO + i*tvac_pkg::EDGE_BITS +: tvac_pkg::EDGE_BITS];
        end
    end

    tvac_front #(
        .MAX_EDGES  (MAX_EDGES),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .scale_value (scale_value_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .angle_a     (s_tdata[0 +: ANGLE_BITS]),
        .angle_b     (s_tdata[ANGLE_BITS +: ANGLE_BITS]),
        .angle_c     (s_tdata[2*ANGLE_BITS +: ANGLE_BITS]),
        .orient_sign (s_tdata[3*ANGLE_BITS +: tvac_pkg::ORIENT_BITS]),
        .edges       (edges),
        .last_tet    (s_tlast),
        .no_tets     (s_tuser),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data)
    );

    tvac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ready  (cmd_ready),
        .in_data   (cmd_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    tvac_back #(
        .MAX_EDGES (MAX_EDGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .orientable (orientable_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_data   (res_data)
    );

    assign m_tdata = {(tvac_pkg::OUT_TDATA_W - 3)'(0), res_data};

endmodule

@@ rtl/tvac_front.sv @@
// Front end: classifies each tetrahedron beat and keeps the strict and taut runs.
// Depends on tvac_pkg; feeds item commands to tvac_queue.
module tvac_front #(
    parameter int MAX_EDGES  = tvac_pkg::MAX_EDGES_DEF,
    parameter int ANGLE_BITS = tvac_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [ANGLE_BITS-1:0]                  scale_value,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [ANGLE_BITS-1:0]                  angle_a,
    input  logic [ANGLE_BITS-1:0]                  angle_b,
    input  logic [ANGLE_BITS-1:0]                  angle_c,
    input  logic [tvac_pkg::ORIENT_BITS-1:0]       orient_sign,
    input  logic [5:0][tvac_pkg::EDGE_BITS-1:0]    edges,
    input  logic                                   last_tet,
    input  logic                                   no_tets,
    output logic                                   cmd_valid,
    input  logic                                   cmd_ready,
    output tvac_pkg::item_cmd_t                    cmd_data
);

    logic strict_run_reg, strict_run_next;
    logic taut_run_reg, taut_run_next;
    logic accept;
    logic [2:0] eq_s, zr;
    logic strict_hit, taut_hit;
    logic sgn;
    logic [5:0] in_rng;
    tvac_pkg::paint_t [3:0] paints;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;
    assign sgn       = orient_sign[tvac_pkg::ORIENT_BITS-1];

    // Compare each angle against pi and against zero.
    assign eq_s[0] = (angle_a == scale_value);
    assign eq_s[1] = (angle_b == scale_value);
    assign eq_s[2] = (angle_c == scale_value);
    assign zr[0]   = (angle_a == '0);
    assign zr[1]   = (angle_b == '0);
    assign zr[2]   = (angle_c == '0);

    // The scan stops at the first angle equal to pi.
    assign strict_hit = eq_s[0] || zr[0]
                     || (!eq_s[0] && (eq_s[1] || zr[1]))
                     || (!eq_s[0] && !eq_s[1] && (eq_s[2] || zr[2]));
    assign taut_hit   = (!eq_s[0] && !zr[0])
                     || (!eq_s[0] && !eq_s[1] && !zr[1])
                     || (!eq_s[0] && !eq_s[1] && !eq_s[2] && !zr[2]);

    // Edge indexes at or above the table size are not painted.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            in_rng[i] = (32'(edges[i]) < 32'(MAX_EDGES));
        end
    end

    // Paint list keyed on the first positive angle.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            paints[i] = '0;
        end
        if (!zr[0])
        begin
            paints[0] = '{vld: in_rng[1], neg: sgn,  edge_idx: edges[1]};
            paints[1] = '{vld: in_rng[4], neg: sgn,  edge_idx: edges[4]};
            paints[2] = '{vld: in_rng[2], neg: !sgn, edge_idx: edges[2]};
            paints[3] = '{vld: in_rng[3], neg: !sgn, edge_idx: edges[3]};
        end
        else if (!zr[1])
        begin
            paints[0] = '{vld: in_rng[2], neg: sgn,  edge_idx: edges[2]};
            paints[1] = '{vld: in_rng[3], neg: sgn,  edge_idx: edges[3]};
            paints[2] = '{vld: in_rng[0], neg: !sgn, edge_idx: edges[0]};
            paints[3] = '{vld: in_rng[5], neg: !sgn, edge_idx: edges[5]};
        end
        else if (!zr[2])
        begin
            paints[0] = '{vld: in_rng[0], neg: sgn,  edge_idx: edges[0]};
            paints[1] = '{vld: in_rng[5], neg: sgn,  edge_idx: edges[5]};
            paints[2] = '{vld: in_rng[1], neg: !sgn, edge_idx: edges[1]};
            paints[3] = '{vld: in_rng[4], neg: !sgn, edge_idx: edges[4]};
        end
    end

    // Build the command and the next values of the running flags.
    always_comb
    begin
        cmd_data        = '0;
        cmd_data.last   = last_tet;
        cmd_data.empty  = no_tets;
        strict_run_next = strict_run_reg;
        taut_run_next   = taut_run_reg;
        if (no_tets)
        begin
            cmd_data.strict = 1'b1;
            cmd_data.taut   = 1'b1;
        end
        else
        begin
            cmd_data.paint  = paints;
            cmd_data.strict = strict_run_reg && !strict_hit;
            cmd_data.taut   = taut_run_reg && !taut_hit;
        end
        if (accept)
        begin
            if (no_tets || last_tet)
            begin
                strict_run_next = 1'b1;
                taut_run_next   = 1'b1;
            end
            else
            begin
                strict_run_next = cmd_data.strict;
                taut_run_next   = cmd_data.taut;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_run_reg <= 1'b1;
            taut_run_reg   <= 1'b1;
        end
        else
        begin
            strict_run_reg <= strict_run_next;
            taut_run_reg   <= taut_run_next;
        end
    end

endmodule

@@ rtl/tvac_queue.sv @@
// Short command queue that decouples the front end from the colour-table back end.
// Depends on tvac_pkg for the command type and depth.
module tvac_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tvac_pkg::item_cmd_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tvac_pkg::item_cmd_t out_data
);

    tvac_pkg::item_cmd_t slots [tvac_pkg::QUEUE_DEPTH];
    logic [tvac_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tvac_pkg::QPTR_BITS:0]   count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != (tvac_pkg::QPTR_BITS+1)'(tvac_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slots[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/tvac_back.sv @@
// Back end: runs the paint slots of each command against the epoch-tagged colour
// table and forms the result beat. Depends on tvac_pkg; fed by tvac_queue.
module tvac_back #(
    parameter int MAX_EDGES = tvac_pkg::MAX_EDGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                orientable,
    input  logic                q_valid,
    output logic                q_ready,
    input  tvac_pkg::item_cmd_t q_data,
    output logic                res_valid,
    input  logic                res_ready,
    output tvac_pkg::result_t   res_data
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int MW = tvac_pkg::EPOCH_BITS + 1;

    // Colour table: {epoch tag, negative colour}.
    logic [MW-1:0] colour_mem [MAX_EDGES];
    logic [MW-1:0] rd_data_reg;

    tvac_pkg::back_state_t state_reg, state_next;
    logic [tvac_pkg::EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [tvac_pkg::SLOT_BITS-1:0] slot_reg;

    // Second stage record.
    logic                            m_vld_reg, m_pv_reg, m_neg_reg, m_end_reg, m_empty_reg;
    logic                            m_strict_reg, m_taut_reg;
    logic [AW-1:0]                   m_addr_reg;
    logic [tvac_pkg::EPOCH_BITS-1:0] m_epoch_reg;

    // Last table write, for the read that happened at the same edge.
    logic                            fwd_vld_reg;
    logic                            fwd_neg_reg;
    logic [AW-1:0]                   fwd_addr_reg;
    logic [tvac_pkg::EPOCH_BITS-1:0] fwd_epoch_reg;

    logic                  veer_run_reg;
    logic                  out_valid_reg;
    tvac_pkg::result_t     out_data_reg;

    tvac_pkg::paint_t cur;
    logic [tvac_pkg::EDGE_BITS+AW-1:0] cur_ext;
    logic [AW-1:0] cur_addr;
    logic end_slot, end_item, out_free, issue, clr_we;
    logic hit_fwd, present, stored_neg, conflict, paint_we, veer_after;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    // Issue stage: one paint slot a cycle from the head command unless stalled.
    assign cur      = q_data.paint[slot_reg];
    assign cur_ext  = {AW'(0), cur.edge_idx};
    assign cur_addr = cur_ext[AW-1:0];
    assign end_slot = (slot_reg == tvac_pkg::LAST_SLOT);
    assign end_item = q_data.last || q_data.empty;
    assign out_free = (!out_valid_reg || res_ready) && !(m_vld_reg && m_end_reg);
    assign issue    = (state_reg == tvac_pkg::BK_RUN) && q_valid
                   && (!(end_slot && end_item) || out_free);
    assign q_ready  = issue && end_slot;

    // Sequencer: clearing pass, epoch advance.
    always_comb
    begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        clr_we        = 1'b0;
        case (state_reg)
            tvac_pkg::BK_CLEAR:
            begin
                if (!m_vld_reg)
                begin
                    clr_we        = 1'b1;
                    clr_addr_next = clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(MAX_EDGES - 1))
                    begin
                        clr_addr_next = '0;
                        state_next    = tvac_pkg::BK_RUN;
                    end
                end
            end
            tvac_pkg::BK_RUN:
            begin
                if (q_ready && end_item)
                begin
                    if (epoch_reg == tvac_pkg::EPOCH_LAST)
                    begin
                        epoch_next = tvac_pkg::EPOCH_FIRST;
                        state_next = tvac_pkg::BK_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = tvac_pkg::BK_CLEAR;
            end
        endcase
    end

    // Resolve the current colour of the edge and check for a conflict.
    assign hit_fwd    = fwd_vld_reg && (fwd_addr_reg == m_addr_reg)
                     && (fwd_epoch_reg == m_epoch_reg);
    assign present    = hit_fwd || (rd_data_reg[MW-1:1] == m_epoch_reg);
    assign stored_neg = hit_fwd ? fwd_neg_reg : rd_data_reg[0];
    assign conflict   = m_vld_reg && m_pv_reg && present && (stored_neg != m_neg_reg);
    assign paint_we   = m_vld_reg && m_pv_reg && !conflict;
    assign veer_after = veer_run_reg && !conflict;

    // Single write port shared by the paint stage and the clearing pass.
    assign wr_addr = clr_we ? clr_addr_reg : m_addr_reg;
    assign wr_data = clr_we ? {tvac_pkg::EPOCH_NONE, 1'b0} : {m_epoch_reg, m_neg_reg};

    always_ff @(posedge clk)
    begin
        if (clr_we || paint_we)
        begin
            colour_mem[wr_addr] <= wr_data;
        end
        if (issue && cur.vld)
        begin
            rd_data_reg <= colour_mem[cur_addr];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvac_pkg::BK_CLEAR;
            epoch_reg     <= tvac_pkg::EPOCH_FIRST;
            clr_addr_reg  <= '0;
            slot_reg      <= '0;
            m_vld_reg     <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            veer_run_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            if (issue)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            m_vld_reg   <= issue;
            fwd_vld_reg <= paint_we;
            if (m_vld_reg && m_end_reg)
            begin
                veer_run_reg <= 1'b1;
            end
            else if (conflict)
            begin
                veer_run_reg <= 1'b0;
            end
            if (m_vld_reg && m_end_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the paint stage, forward path and result.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m_pv_reg     <= cur.vld;
            m_neg_reg    <= cur.neg;
            m_addr_reg   <= cur_addr;
            m_epoch_reg  <= epoch_reg;
            m_end_reg    <= end_slot && end_item;
            m_empty_reg  <= q_data.empty;
            m_strict_reg <= q_data.strict;
            m_taut_reg   <= q_data.taut;
        end
        fwd_neg_reg   <= m_neg_reg;
        fwd_addr_reg  <= m_addr_reg;
        fwd_epoch_reg <= m_epoch_reg;
        if (m_vld_reg && m_end_reg)
        begin
            out_data_reg.is_strict  <= m_strict_reg;
            out_data_reg.is_taut    <= m_taut_reg;
            out_data_reg.is_veering <= m_empty_reg
                                    || (m_taut_reg && orientable && veer_after);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // The clearing pass and the paint stage never write in the same cycle.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_we && paint_we))
        else $error("colour table written by clear and paint together");

    // No paint slot is issued while the table is being cleared.
    a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tvac_pkg::BK_CLEAR) |-> !issue)
        else $error("paint issued during clearing pass");

    // A result is only formed when the output register has room for it.
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |=> !(m_vld_reg && m_end_reg))
        else $error("result formed over a waiting result");

    // The live epoch never equals the cleared tag.
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != tvac_pkg::EPOCH_NONE)
        else $error("epoch equals cleared tag");

endmodule

@@ bench/tb_taut_veering_angle_classifier_top.sv @@
// Self-checking testbench for taut_veering_angle_classifier_top: directed rows, then
// random structures checked against a predictor in this file.
// Depends on tvac_pkg and the block's RTL; needs no files or arguments at run time.
`timescale 1ns / 100ps

module tb_taut_veering_angle_classifier_top;

    import tvac_pkg::*;

    localparam int MAX_EDGES    = MAX_EDGES_DEF;
    localparam int ANGLE_W      = ANGLE_BITS_DEF;
    localparam int TET_BITS     = 3 * ANGLE_W + ORIENT_BITS + 6 * EDGE_BITS;
    localparam int S_TDATA_W    = ((TET_BITS + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 32;
    localparam int TAIL_CYCLES  = 40;
    localparam int STUCK_LIMIT  = 8000;
    localparam int RANDOM_BEATS = 650;
    localparam int N_PHASES     = 7;

    // Color held by one edge within the current structure.
    typedef enum logic [1:0] {
        HUE_NONE,
        HUE_PLUS,
        HUE_MINUS
    } edge_color_t;

    // One tetrahedron beat, all fields at the block's widths.
    typedef struct packed {
        logic                            no_tets;
        logic                            last;
        logic [5:0][EDGE_BITS-1:0]       edges;
        logic [ORIENT_BITS-1:0]          orient;  // sign bit set means minus one
        logic [ANGLE_W-1:0]              ang_c;
        logic [ANGLE_W-1:0]              ang_b;
        logic [ANGLE_W-1:0]              ang_a;
    } tet_beat_t;

    typedef enum logic {
        ROW_CFG,
        ROW_TET
    } row_kind_t;

    // One row of the directed table.
    typedef struct {
        row_kind_t    kind;
        logic [ANGLE_W-1:0] scale;
        logic         orientable;
        tet_beat_t    beat;
        bit           typed;
        result_t      want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
    logic [ANGLE_W-1:0]     cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predictor state and its copy of the configuration.
    edge_color_t        edge_color [MAX_EDGES];
    bit                 strict_acc = 1'b1;
    bit                 taut_acc = 1'b1;
    bit                 veer_acc = 1'b1;
    logic [ANGLE_W-1:0] scale_q = '0;
    logic               orient_q = 1'b0;

    result_t     verdict_q [$];
    plan_row_t   plan_q [$];
    int          fail_count = 0;
    int unsigned stuck_cycles = 0;
    int unsigned sink_hold = 0;
    bit          sink_calm = 1'b0;
    bit          src_calm = 1'b0;
    int unsigned beats_sent;
    result_t     mon_want;
    result_t     mon_got;

    taut_veering_angle_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // angle_a, angle_b, angle_c, orient_sign, edge_0 .. edge_5
        .s_tlast   (s_tlast),   // last_tet
        .s_tuser   (s_tuser),   // no_tets
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // is_strict, is_taut, is_veering
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void wipe_structure();
        for (int i = 0; i < MAX_EDGES; i++)
        begin
            edge_color[i] = HUE_NONE;
        end
        strict_acc = 1'b1;
        taut_acc   = 1'b1;
        veer_acc   = 1'b1;
    endfunction

    function automatic edge_color_t opposite(input edge_color_t h);
        return (h == HUE_PLUS) ? HUE_MINUS : HUE_PLUS;
    endfunction

    // Paint one edge; meeting the opposite color breaks the veering run.
    function automatic void paint_edge(input logic [EDGE_BITS-1:0] e, input edge_color_t h);
        if (e < MAX_EDGES)
        begin
            if (edge_color[e] == opposite(h))
                veer_acc = 1'b0;
            else
                edge_color[e] = h;
        end
    endfunction

    // Fold one beat into the running flags; returns 1 with the verdict when it closes a
    // structure.
    function automatic bit classify_beat(input tet_beat_t b, output result_t r);
        logic [ANGLE_W-1:0] ang [3];
        edge_color_t        pos;
        edge_color_t        neg;
        bit                 hit_pi;
        r = '0;
        if (b.no_tets)
        begin
            wipe_structure();
            r.is_strict  = 1'b1;
            r.is_taut    = 1'b1;
            r.is_veering = 1'b1;
            return 1'b1;
        end
        ang[0] = b.ang_a;
        ang[1] = b.ang_b;
        ang[2] = b.ang_c;
        hit_pi = 1'b0;

        // The scan stops at the first angle equal to pi.
        for (int p = 0; p < 3 && !hit_pi; p++)
        begin
            if (ang[p] == scale_q)
            begin
                strict_acc = 1'b0;
                hit_pi     = 1'b1;
            end
            else if (ang[p] == '0)
                strict_acc = 1'b0;
            else
                taut_acc = 1'b0;
        end

        // Coloring follows the first positive angle of the tetrahedron.
        pos = b.orient[ORIENT_BITS-1] ? HUE_MINUS : HUE_PLUS;
        neg = opposite(pos);
        if (veer_acc)
        begin
            if (ang[0] != '0)
            begin
                paint_edge(b.edges[1], pos);
                paint_edge(b.edges[4], pos);
                paint_edge(b.edges[2], neg);
                paint_edge(b.edges[3], neg);
            end
            else if (ang[1] != '0)
            begin
                paint_edge(b.edges[2], pos);
                paint_edge(b.edges[3], pos);
                paint_edge(b.edges[0], neg);
                paint_edge(b.edges[5], neg);
            end
            else if (ang[2] != '0)
            begin
                paint_edge(b.edges[0], pos);
                paint_edge(b.edges[5], pos);
                paint_edge(b.edges[1], neg);
                paint_edge(b.edges[4], neg);
            end
        end

        if (!b.last)
            return 1'b0;
        r.is_strict  = strict_acc;
        r.is_taut    = taut_acc;
        r.is_veering = taut_acc && orient_q && veer_acc;
        wipe_structure();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic result_t verdict(input int strict, input int taut, input int veer);
        result_t r;
        r.is_strict  = (strict != 0);
        r.is_taut    = (taut != 0);
        r.is_veering = (veer != 0);
        return r;
    endfunction

    function automatic logic [5:0][EDGE_BITS-1:0] edge_set(input int e0, input int e1,
                                                           input int e2, input int e3,
                                                           input int e4, input int e5);
        return {EDGE_BITS'(e5), EDGE_BITS'(e4), EDGE_BITS'(e3),
                EDGE_BITS'(e2), EDGE_BITS'(e1), EDGE_BITS'(e0)};
    endfunction

    function automatic void plan_cfg(input logic [ANGLE_W-1:0] scale, input logic orientable);
        plan_row_t row;
        row.kind       = ROW_CFG;
        row.scale      = scale;
        row.orientable = orientable;
        row.beat       = '0;
        row.typed      = 1'b0;
        row.want       = '0;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_tet(input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] b,
                                     input logic [ANGLE_W-1:0] c,
                                     input logic [ORIENT_BITS-1:0] orient,
                                     input logic [5:0][EDGE_BITS-1:0] edges,
                                     input bit last, input bit empty,
                                     input bit typed, input result_t want);
        plan_row_t row;
        row.kind         = ROW_TET;
        row.scale        = '0;
        row.orientable   = 1'b0;
        row.beat         = '0;
        row.beat.ang_a   = a;
        row.beat.ang_b   = b;
        row.beat.ang_c   = c;
        row.beat.orient  = orient;
        row.beat.edges   = edges;
        row.beat.last    = last;
        row.beat.no_tets = empty;
        row.typed        = typed;
        row.want         = want;
        plan_q.push_back(row);
    endfunction

    // An angle from the interesting corners around the current scale.
    function automatic logic [ANGLE_W-1:0] odd_angle();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return scale_q;
            2: return scale_q + 1'b1;
            3: return scale_q - 1'b1;
            4: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Styles: below 55 taut-shaped, below 75 strict-shaped, otherwise noise.
    function automatic tet_beat_t random_tet(input int unsigned style, input int unsigned base);
        tet_beat_t          b;
        int unsigned        pi_at;
        logic [ANGLE_W-1:0] ang [3];
        b        = '0;
        b.orient = ORIENT_BITS'($urandom_range(0, 3));
        pi_at    = $urandom_range(0, 3);
        for (int p = 0; p < 3; p++)
        begin
            if (style < 55)
                ang[p] = (p < pi_at) ? '0 : (p == pi_at) ? scale_q :
                         (($urandom_range(0, 3) == 0) ? odd_angle() : '0);
            else if (style < 75)
                ang[p] = (scale_q > 1) ? $urandom_range(1, scale_q - 1) : $urandom();
            else
                ang[p] = odd_angle();
        end
        // A stray angle now and then breaks an otherwise taut structure.
        if (style < 55 && $urandom_range(0, 19) == 0)
            ang[$urandom_range(0, 2)] = $urandom();
        for (int k = 0; k < 6; k++)
        begin
            b.edges[k] = (style < 55) ? EDGE_BITS'(base + $urandom_range(0, 11))
                                      : EDGE_BITS'($urandom_range(0, MAX_EDGES - 1));
        end
        b.ang_a = ang[0];
        b.ang_b = ang[1];
        b.ang_c = ang[2];
        return b;
    endfunction

    // Offer one beat, wait for its handshake, then record what it should produce.
    task automatic push_beat(input tet_beat_t b, input bit typed, input result_t want);
        int unsigned gap;
        result_t     pred;
        gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - TET_BITS){1'b0}}, b.edges, b.orient, b.ang_c, b.ang_b,
                     b.ang_a};
        s_tlast  <= b.last;
        s_tuser  <= b.no_tets;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (classify_beat(b, pred))
            verdict_q.push_back(typed ? want : pred);
    endtask

    // Wait for the block to drain, then write both registers.
    task automatic apply_config(input logic [ANGLE_W-1:0] scale, input logic orientable);
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SCALE;
        cfg_wdata <= scale;
        @(posedge clk);
        cfg_addr  <= REG_ORIENT;
        cfg_wdata <= ANGLE_W'(orientable);
        @(posedge clk);
        cfg_we    <= 1'b0;
        scale_q  = scale;
        orient_q = orientable;
    endtask

    // One random structure; it always ends on a beat that yields a verdict.
    task automatic run_structure();
        int unsigned style;
        int unsigned n_tets;
        int unsigned base;
        tet_beat_t   b;
        style    = $urandom_range(0, 99);
        n_tets   = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        base     = $urandom_range(0, MAX_EDGES - 12);
        src_calm = ($urandom_range(0, 5) == 0);
        for (int t = 0; t < n_tets; t++)
        begin
            b      = random_tet(style, base);
            b.last = (t == n_tets - 1);
            // Broken structures are abandoned by an empty marker.
            if (style >= 90 && t == n_tets - 1)
            begin
                b.no_tets = 1'b1;
                b.last    = 1'($urandom_range(0, 1));
            end
            push_beat(b, 1'b0, '0);
            beats_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [ANGLE_W-1:0] phase_scale [N_PHASES];
        bit                 phase_orient [N_PHASES];
        phase_scale  = '{32'd6, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1000, 32'd2, 32'd100};
        phase_orient = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        wipe_structure();

        // Directed table; reset configuration first: scale zero, not orientable.
        plan_tet('1, '1, '1, 2'b11, edge_set(1023, 1023, 1023, 1023, 1023, 1023),
                 1'b0, 1'b1, 1'b1, verdict(1, 1, 1));
        // Zero scale makes a zero angle count as pi.
        plan_tet(0, 0, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 0));
        plan_cfg(32'd6, 1'b1);
        plan_tet(6, 0, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 1));
        plan_tet(2, 2, 2, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(1, 0, 0));
        // Opposite orientations on the same edges conflict.
        plan_tet(6, 0, 0, 2'b01, edge_set(0, 10, 11, 12, 13, 5), 1'b0, 1'b0, 1'b0, '0);
        plan_tet(6, 0, 0, 2'b11, edge_set(0, 10, 11, 12, 13, 5), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 0));
        plan_tet('1, '1, '1, 2'b11, edge_set(1023, 0, 1023, 0, 1023, 0), 1'b1, 1'b0, 1'b1,
                 verdict(1, 0, 0));
        // An empty marker drops a structure part way through and clears the colors.
        plan_tet(0, 6, 0, 2'b01, edge_set(0, 7, 8, 9, 20, 1023), 1'b0, 1'b0, 1'b0, '0);
        plan_tet(32'h5555_5555, 32'hAAAA_AAAA, 0, 2'b10, edge_set(0, 7, 8, 9, 20, 1023),
                 1'b1, 1'b1, 1'b1, verdict(1, 1, 1));
        plan_tet(0, 0, 6, 2'b00, edge_set(0, 7, 8, 9, 20, 1023), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 1));
        // Repeated edges within one tetrahedron.
        plan_tet(6, 0, 0, 2'b01, edge_set(1023, 1023, 1023, 1023, 1023, 1023), 1'b1, 1'b0,
                 1'b1, verdict(0, 1, 0));
        // The scan stops at the first pi.
        plan_tet(6, 3, 3, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 1));
        plan_tet(0, 6, 3, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 1));
        plan_tet(3, 6, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 0, 0));
        plan_tet(5, 1, 4, 2'b00, edge_set(30, 31, 32, 33, 34, 35), 1'b0, 1'b0, 1'b0, '0);
        plan_tet(5, 1, 4, 2'b10, edge_set(30, 31, 32, 33, 34, 35), 1'b1, 1'b0, 1'b1,
                 verdict(1, 0, 0));
        plan_tet(0, 0, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b0, 1'b0, 1'b0, '0);
        plan_tet(6, '1, 0, 2'b11, edge_set(2, 4, 6, 8, 10, 12), 1'b1, 1'b0, 1'b0, '0);
        plan_cfg(32'd6, 1'b0);
        plan_tet(6, 0, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 0));
        plan_cfg(32'hFFFF_FFFF, 1'b1);
        plan_tet('1, 0, 0, 2'b01, edge_set(1, 2, 3, 4, 5, 6), 1'b1, 1'b0, 1'b1,
                 verdict(0, 1, 1));
        plan_tet(32'hFFFF_FFFE, 1, 32'h8000_0000, 2'b01, edge_set(1, 2, 3, 4, 5, 6),
                 1'b1, 1'b0, 1'b1, verdict(1, 0, 0));

        // Hold reset, then release it.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_q[i])
        begin
            if (plan_q[i].kind == ROW_CFG)
            begin
                s_tvalid <= 1'b0;
                apply_config(plan_q[i].scale, plan_q[i].orientable);
            end
            else
                push_beat(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);
        end

        // Random structures under several configurations.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            apply_config(phase_scale[ph], phase_orient[ph]);
            beats_sent = 0;
            while (beats_sent < RANDOM_BEATS / N_PHASES)
                run_structure();
        end

        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result sink with random back-pressure and calm stretches.
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0)
                sink_hold <= idle_len();
        end
        if ($urandom_range(0, 299) == 0)
            sink_calm <= ~sink_calm;
    end

    // Compare each result beat with the oldest expected verdict.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat %b with no verdict pending", m_tdata);
                fail_count++;
            end
            else
            begin
                mon_want = verdict_q.pop_front();
                mon_got  = m_tdata[2:0];
                if (mon_got.is_strict !== mon_want.is_strict)
                begin
                    $error("is_strict: expected %0d, got %0d", mon_want.is_strict,
                           mon_got.is_strict);
                    fail_count++;
                end
                if (mon_got.is_taut !== mon_want.is_taut)
                begin
                    $error("is_taut: expected %0d, got %0d", mon_want.is_taut,
                           mon_got.is_taut);
                    fail_count++;
                end
                if (mon_got.is_veering !== mon_want.is_veering)
                begin
                    $error("is_veering: expected %0d, got %0d", mon_want.is_veering,
                           mon_got.is_veering);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $error("no beat accepted for %0d cycles", STUCK_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

endmodule
